// ===== design/d2qig_pkg.sv =====
// ----------------------------------------------------------------------------
// d2qig_pkg
// Shared operation and boundary-normal codes for the D2Q9 gradient block.
// ----------------------------------------------------------------------------
package d2qig_pkg;

   typedef enum logic [1:0] {
      OP_INTERIOR = 2'd0,
      OP_BOUNDARY = 2'd1,
      OP_CORNER   = 2'd2
   } op_type;

   typedef logic [3:0] normal_type;

   localparam normal_type NRM_W  = 4'd1;
   localparam normal_type NRM_S  = 4'd2;
   localparam normal_type NRM_E  = 4'd3;
   localparam normal_type NRM_N  = 4'd4;
   localparam normal_type NRM_SW = 4'd5;
   localparam normal_type NRM_SE = 4'd6;
   localparam normal_type NRM_NE = 4'd7;
   localparam normal_type NRM_NW = 4'd8;

endpackage

// ===== design/d2qig_if.sv =====
// ----------------------------------------------------------------------------
// d2qig_if
// Valid/ready channels for the D2Q9 gradient block: node request, gradient.
// ----------------------------------------------------------------------------
interface d2qig_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic [3:0]                    normal;
   logic signed [VALUE_WIDTH-1:0] v_center;
   logic signed [VALUE_WIDTH-1:0] v_east;
   logic signed [VALUE_WIDTH-1:0] v_north;
   logic signed [VALUE_WIDTH-1:0] v_west;
   logic signed [VALUE_WIDTH-1:0] v_south;
   logic signed [VALUE_WIDTH-1:0] v_northeast;
   logic signed [VALUE_WIDTH-1:0] v_northwest;
   logic signed [VALUE_WIDTH-1:0] v_southwest;
   logic signed [VALUE_WIDTH-1:0] v_southeast;

   modport source (
      output valid, op, normal, v_center, v_east, v_north, v_west, v_south,
             v_northeast, v_northwest, v_southwest, v_southeast,
      input  ready
   );
   modport sink (
      input  valid, op, normal, v_center, v_east, v_north, v_west, v_south,
             v_northeast, v_northwest, v_southwest, v_southeast,
      output ready
   );
endinterface

interface d2qig_rsp_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                        valid;
   logic                        ready;
   logic signed [VALUE_WIDTH:0] grad_x;
   logic signed [VALUE_WIDTH:0] grad_y;
   logic                        bad_normal;

   modport source (
      output valid, grad_x, grad_y, bad_normal,
      input  ready
   );
   modport sink (
      input  valid, grad_x, grad_y, bad_normal,
      output ready
   );
endinterface

// ===== design/d2q9_isotropic_gradient.sv =====
// ----------------------------------------------------------------------------
// d2q9_isotropic_gradient
// Scalar gradient of a D2Q9 neighborhood: isotropic, boundary and corner.
// ----------------------------------------------------------------------------
// One lattice node enters per cycle unless the result side stalls; its gradient
// passes the input register, sum stage, partial-product stage and result register
// in order; each stage advances whenever the stage after it is empty or moving,
// so the sustained rate is one node per clock while the result side keeps taking.
// The isotropic stencil divides by 12 with truncation toward zero: the sum
// magnitude is shifted right by two and multiplied by a reciprocal of three,
// split in two halves whose products are added in the last stage. Boundary
// mode with a normal code outside 1..8 returns zero and raises bad_normal;
// op code 3 returns zero.
module d2q9_isotropic_gradient
   import d2qig_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input logic              clock,
   input logic              reset,
   d2qig_req_if.sink        req_ch,
   d2qig_rsp_if.source      rsp_ch
);

   localparam int W   = VALUE_WIDTH;
   localparam int GW  = W + 1;          // gradient and difference width
   localparam int SW  = W + 4;          // stencil sum width
   localparam int QW  = W + 1;          // sum magnitude divided by four
   localparam int S   = QW + 1 - (QW % 2);  // odd shift so 3*R = 2^S + 1
   localparam int RW  = S;
   localparam int HL  = QW / 2;
   localparam int HH  = QW - HL;
   localparam int PLW = HL + RW;
   localparam int PHW = HH + RW;
   localparam int TW  = QW + RW + 1;

   localparam logic [S:0]    POW        = {1'b1, {S{1'b0}}};
   localparam logic [S:0]    RECIP_FULL = (POW + 1) / 3;
   localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];

   function automatic logic signed [GW-1:0] half_trunc(input logic signed [GW-1:0] d);
      logic signed [GW-1:0] adj;
      adj = d + GW'(d[GW-1]);
      return adj >>> 1;
   endfunction

   // --------------------------------------------------------------- enables
   logic s0_v_ff, s1_v_ff, s2_v_ff, out_v_ff;
   logic s0_en, s1_en, s2_en, out_en;

   assign out_en       = !out_v_ff || rsp_ch.ready;
   assign s2_en        = !s2_v_ff || out_en;
   assign s1_en        = !s1_v_ff || s2_en;
   assign s0_en        = !s0_v_ff || s1_en;
   assign req_ch.ready = s0_en;

   // ---------------------------------------------------------- input stage
   logic [1:0]            op_ff;
   normal_type            normal_ff;
   logic signed [W-1:0]   c_ff, e_ff, n_ff, w_ff, s_ff, ne_ff, nw_ff, sw_ff, se_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_en) begin
         s0_v_ff <= req_ch.valid;
      end
      if (s0_en && req_ch.valid) begin
         op_ff     <= req_ch.op;
         normal_ff <= req_ch.normal;
         c_ff      <= req_ch.v_center;
         e_ff      <= req_ch.v_east;
         n_ff      <= req_ch.v_north;
         w_ff      <= req_ch.v_west;
         s_ff      <= req_ch.v_south;
         ne_ff     <= req_ch.v_northeast;
         nw_ff     <= req_ch.v_northwest;
         sw_ff     <= req_ch.v_southwest;
         se_ff     <= req_ch.v_southeast;
      end
   end

   // ------------------------------------------------------------ sum stage
   typedef struct packed {
      logic                 use_div;
      logic                 neg_x;
      logic                 neg_y;
      logic [QW-1:0]        q_x;
      logic [QW-1:0]        q_y;
      logic signed [GW-1:0] alt_x;
      logic signed [GW-1:0] alt_y;
      logic                 bad;
   } sum_stage_type;

   sum_stage_type        s1_in, s1_ff;
   logic signed [GW-1:0] dx, dy, hx, hy, ec, cw, nc, cs;
   logic signed [SW-1:0] sum_x, sum_y, mag_x, mag_y;

   always_comb begin
      dx = GW'(e_ff) - GW'(w_ff);
      dy = GW'(n_ff) - GW'(s_ff);
      ec = GW'(e_ff) - GW'(c_ff);
      cw = GW'(c_ff) - GW'(w_ff);
      nc = GW'(n_ff) - GW'(c_ff);
      cs = GW'(c_ff) - GW'(s_ff);
      hx = half_trunc(dx);
      hy = half_trunc(dy);
      sum_x = (SW'(dx) <<< 2) + SW'(ne_ff) - SW'(nw_ff) - SW'(sw_ff) + SW'(se_ff);
      sum_y = (SW'(dy) <<< 2) + SW'(ne_ff) + SW'(nw_ff) - SW'(sw_ff) - SW'(se_ff);
      mag_x = sum_x[SW-1] ? -sum_x : sum_x;
      mag_y = sum_y[SW-1] ? -sum_y : sum_y;

      s1_in.use_div = 1'b0;
      s1_in.neg_x   = sum_x[SW-1];
      s1_in.neg_y   = sum_y[SW-1];
      s1_in.q_x     = mag_x[QW+1:2];
      s1_in.q_y     = mag_y[QW+1:2];
      s1_in.alt_x   = '0;
      s1_in.alt_y   = '0;
      s1_in.bad     = 1'b0;

      case (op_ff)
         OP_INTERIOR: begin
            s1_in.use_div = 1'b1;
         end
         OP_CORNER: begin
            s1_in.alt_x = hx;
            s1_in.alt_y = hy;
         end
         OP_BOUNDARY: begin
            case (normal_ff)
               NRM_W:  begin s1_in.alt_x = ec; s1_in.alt_y = hy; end
               NRM_S:  begin s1_in.alt_x = hx; s1_in.alt_y = nc; end
               NRM_E:  begin s1_in.alt_x = cw; s1_in.alt_y = hy; end
               NRM_N:  begin s1_in.alt_x = hx; s1_in.alt_y = cs; end
               NRM_SW: begin s1_in.alt_x = ec; s1_in.alt_y = nc; end
               NRM_SE: begin s1_in.alt_x = cw; s1_in.alt_y = nc; end
               NRM_NE: begin s1_in.alt_x = cw; s1_in.alt_y = cs; end
               NRM_NW: begin s1_in.alt_x = ec; s1_in.alt_y = cs; end
               default: begin
                  s1_in.bad = 1'b1;
               end
            endcase
         end
         default: begin
            s1_in.use_div = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= s0_v_ff;
      end
      if (s1_en && s0_v_ff) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------ partial-product stage
   typedef struct packed {
      logic                 use_div;
      logic                 neg_x;
      logic                 neg_y;
      logic [PHW-1:0]       ph_x;
      logic [PLW-1:0]       pl_x;
      logic [PHW-1:0]       ph_y;
      logic [PLW-1:0]       pl_y;
      logic signed [GW-1:0] alt_x;
      logic signed [GW-1:0] alt_y;
      logic                 bad;
   } prod_stage_type;

   prod_stage_type s2_in, s2_ff;

   always_comb begin
      s2_in.use_div = s1_ff.use_div;
      s2_in.neg_x   = s1_ff.neg_x;
      s2_in.neg_y   = s1_ff.neg_y;
      s2_in.ph_x    = PHW'(s1_ff.q_x[QW-1:HL]) * PHW'(RECIP);
      s2_in.pl_x    = PLW'(s1_ff.q_x[HL-1:0]) * PLW'(RECIP);
      s2_in.ph_y    = PHW'(s1_ff.q_y[QW-1:HL]) * PHW'(RECIP);
      s2_in.pl_y    = PLW'(s1_ff.q_y[HL-1:0]) * PLW'(RECIP);
      s2_in.alt_x   = s1_ff.alt_x;
      s2_in.alt_y   = s1_ff.alt_y;
      s2_in.bad     = s1_ff.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_en && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   // --------------------------------------------------------- result stage
   logic [TW-1:0]        tot_x, tot_y;
   logic [QW-1:0]        quo_x, quo_y;
   logic signed [GW-1:0] gx_in, gy_in;
   logic signed [GW-1:0] gx_ff, gy_ff;
   logic                 bad_ff;

   always_comb begin
      tot_x = (TW'(s2_ff.ph_x) << HL) + TW'(s2_ff.pl_x);
      tot_y = (TW'(s2_ff.ph_y) << HL) + TW'(s2_ff.pl_y);
      quo_x = tot_x[S +: QW];
      quo_y = tot_y[S +: QW];
      if (s2_ff.use_div) begin
         gx_in = s2_ff.neg_x ? -$signed(GW'(quo_x)) : $signed(GW'(quo_x));
         gy_in = s2_ff.neg_y ? -$signed(GW'(quo_y)) : $signed(GW'(quo_y));
      end else begin
         gx_in = s2_ff.alt_x;
         gy_in = s2_ff.alt_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= s2_v_ff;
      end
      if (out_en && s2_v_ff) begin
         gx_ff  <= gx_in;
         gy_ff  <= gy_in;
         bad_ff <= s2_ff.bad;
      end
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.grad_x     = gx_ff;
   assign rsp_ch.grad_y     = gy_ff;
   assign rsp_ch.bad_normal = bad_ff;

   // ------------------------------------------------------------ assertions
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.bad_normal |-> rsp_ch.grad_x == '0 && rsp_ch.grad_y == '0)
      else $error("bad normal item carries a nonzero gradient");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while result side is taking items");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_en |=> s1_v_ff && $stable(s1_ff))
      else $error("sum stage lost or changed a stalled item");

   a_div_only_interior: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_ff.use_div |-> !s1_ff.bad)
      else $error("interior item flagged as bad normal");

endmodule
